### sv/mau_pkg.sv
// Shared widths, register indexes and reset values for the attitude update block.
// No dependencies; every other file in sv/ imports this package.
package mau_pkg;

	localparam int QUAT_WIDTH_DEF = 32;

	localparam int RATE_W  = 32;
	localparam int ACCEL_W = 16;
	localparam int QUAT_W  = 32;

	localparam int GAIN_W = 18;
	localparam int HP_W   = 24;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 2'd2;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 18'd11141;
	localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST = 18'd262;
	localparam logic [HP_W-1:0]   HALF_PERIOD_RST   = 24'd8389;

	// datapath widths
	localparam int MUL_W  = 36;
	localparam int ACC_W  = 66;
	localparam int SQ_IN_W = 64;
	localparam int ROOT_W = 32;
	localparam int DVD_W  = 64;

	typedef logic signed [MUL_W-1:0] mop_t;
	typedef logic signed [ACC_W-1:0] acc_t;

endpackage

### sv/mahony_attitude_update.sv
// Mahony attitude update: sequencer around one shared multiplier, a square root
// unit and a divider. Depends on mau_pkg, mau_mul, mau_isqrt and mau_div.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   cfg     | cfg_write            | cfg_index, cfg_data
//   in      | in_valid / in_stall  | rate_x/y/z, accel_x/y/z
//   out     | out_valid / out_stall| quat_w/x/y/z
//
// Most of the work for a sample is the bit-serial divider (up to seven 64-bit
// quotients) and up to 48 multiplies on the shared multiplier; an all-zero
// acceleration skips the first root, three divides and the correction multiplies.
// in_stall is high from the transfer of a sample until its result is loaded into
// the output register; a stalled result holds the block in its final step.
// Reset gives the unit quaternion, a zero integral and the default gains.
module mahony_attitude_update #(
	parameter int QUAT_WIDTH = mau_pkg::QUAT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [mau_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mau_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [mau_pkg::RATE_W-1:0]    rate_x,
	input  logic signed [mau_pkg::RATE_W-1:0]    rate_y,
	input  logic signed [mau_pkg::RATE_W-1:0]    rate_z,
	input  logic signed [mau_pkg::ACCEL_W-1:0]   accel_x,
	input  logic signed [mau_pkg::ACCEL_W-1:0]   accel_y,
	input  logic signed [mau_pkg::ACCEL_W-1:0]   accel_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mau_pkg::QUAT_W-1:0]    quat_w,
	output logic signed [mau_pkg::QUAT_W-1:0]    quat_x,
	output logic signed [mau_pkg::QUAT_W-1:0]    quat_y,
	output logic signed [mau_pkg::QUAT_W-1:0]    quat_z
);
	import mau_pkg::*;

	localparam int SH_DN = (QUAT_WIDTH >= 32) ? QUAT_WIDTH - 32 : 0;
	localparam int SH_UP = (QUAT_WIDTH < 32) ? 32 - QUAT_WIDTH : 0;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SQRT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// multiply step groups
	localparam logic [5:0] OP_ASQ  = 6'd0;
	localparam logic [5:0] OP_GRAV = 6'd3;
	localparam logic [5:0] OP_ERR  = 6'd11;
	localparam logic [5:0] OP_PI   = 6'd17;
	localparam logic [5:0] OP_HALF = 6'd26;
	localparam logic [5:0] OP_STEP = 6'd32;
	localparam logic [5:0] OP_NORM = 6'd44;
	localparam logic [5:0] OP_LAST = 6'd47;

	localparam acc_t I32_MAX = (ACC_W'(1) << 31) - ACC_W'(1);
	localparam acc_t I32_MIN = -(ACC_W'(1) << 31);
	localparam acc_t H_MAX   = ACC_W'(1) << 29;
	localparam acc_t H_MIN   = -(ACC_W'(1) << 29);
	localparam logic [DVD_W-1:0] ONE30 = DVD_W'(1) << 30;

	function automatic logic signed [31:0] to30(input logic signed [QUAT_WIDTH-1:0] v);
		logic signed [63:0] x;
		x = 64'(v);
		x = (x >>> SH_DN) <<< SH_UP;
		return x[31:0];
	endfunction

	function automatic logic signed [QUAT_WIDTH-1:0] from30(input logic signed [31:0] v);
		logic signed [63:0] x;
		x = 64'(v);
		x = (x <<< SH_DN) >>> SH_UP;
		return x[QUAT_WIDTH-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input acc_t x);
		logic signed [31:0] r;
		if (x > I32_MAX)
			r = 32'(I32_MAX);
		else if (x < I32_MIN)
			r = 32'(I32_MIN);
		else
			r = 32'(x);
		return r;
	endfunction

	function automatic logic signed [31:0] clamp29(input acc_t x);
		logic signed [31:0] r;
		if (x > H_MAX)
			r = 32'(H_MAX);
		else if (x < H_MIN)
			r = 32'(H_MIN);
		else
			r = 32'(x);
		return r;
	endfunction

	// control
	logic [2:0] state_q;
	logic       phase_q, pass_q;
	logic [5:0] op_q;
	logic [1:0] div_idx_q;
	logic       sq_start_q, div_start_q, out_valid_q;

	// configuration and filter state
	logic [GAIN_W-1:0]            prop_q, integ_q;
	logic [HP_W-1:0]              hp_q;
	logic signed [QUAT_WIDTH-1:0] att_q [4];
	logic signed [31:0]           ei_q [3];

	// working values
	logic signed [31:0]     q_q [4];
	logic signed [31:0]     an_q [3];
	logic signed [47:0]     g_q [3];
	logic signed [MUL_W-1:0] v_q [3];
	logic signed [MUL_W-1:0] e_q [3];
	logic signed [31:0]     h_q [3];
	logic signed [33:0]     n_q [4];
	acc_t                   acc_q;
	logic [ROOT_W-1:0]      root_q;
	logic [SQ_IN_W-1:0]     sq_arg_q;
	logic [DVD_W-1:0]       dvd_q;
	logic signed [QUAT_W-1:0] qw_q, qx_q, qy_q, qz_q;

	mop_t                     ma, mb;
	logic signed [2*MUL_W-1:0] prod;
	acc_t                     pt, m_p, acc_plus, acc_minus, acc_pm, acc_mm, acc_sq;

	logic                 sq_done, div_done;
	logic [ROOT_W-1:0]    sq_root;
	logic [DVD_W-1:0]     quot;

	logic signed [33:0] src_all [4];
	logic [1:0]         div_sel;
	logic signed [33:0] src_sel;
	logic [33:0]        src_mag;
	logic [DVD_W-1:0]   dvd_next;
	logic [30:0]        mag31;
	logic signed [31:0] res_mag, div_res;

	logic accept, done_fire, last_div;

	assign accept    = in_valid && !in_stall;
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign last_div  = pass_q ? (div_idx_q == 2'd3) : (div_idx_q == 2'd2);

	mau_mul #(.W(MUL_W)) u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.p   (prod)
	);

	mau_isqrt #(.IN_W(SQ_IN_W), .OUT_W(ROOT_W)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.arg    (sq_arg_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	mau_div #(.DVD_W(DVD_W), .DVS_W(ROOT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dvd_q),
		.divisor  (root_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign pt        = ACC_W'(prod);
	assign m_p       = pt >>> 30;
	assign acc_plus  = acc_q + pt;
	assign acc_minus = acc_q - pt;
	assign acc_pm    = acc_q + m_p;
	assign acc_mm    = acc_q - m_p;
	assign acc_sq    = acc_q + (pt >>> 4);

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (op_q)
			OP_ASQ + 6'd0:  begin ma = mop_t'(an_q[0]); mb = mop_t'(an_q[0]); end
			OP_ASQ + 6'd1:  begin ma = mop_t'(an_q[1]); mb = mop_t'(an_q[1]); end
			OP_ASQ + 6'd2:  begin ma = mop_t'(an_q[2]); mb = mop_t'(an_q[2]); end
			OP_GRAV + 6'd0: begin ma = mop_t'(q_q[1]); mb = mop_t'(q_q[3]); end
			OP_GRAV + 6'd1: begin ma = mop_t'(q_q[0]); mb = mop_t'(q_q[2]); end
			OP_GRAV + 6'd2: begin ma = mop_t'(q_q[0]); mb = mop_t'(q_q[1]); end
			OP_GRAV + 6'd3: begin ma = mop_t'(q_q[2]); mb = mop_t'(q_q[3]); end
			OP_GRAV + 6'd4: begin ma = mop_t'(q_q[0]); mb = mop_t'(q_q[0]); end
			OP_GRAV + 6'd5: begin ma = mop_t'(q_q[1]); mb = mop_t'(q_q[1]); end
			OP_GRAV + 6'd6: begin ma = mop_t'(q_q[2]); mb = mop_t'(q_q[2]); end
			OP_GRAV + 6'd7: begin ma = mop_t'(q_q[3]); mb = mop_t'(q_q[3]); end
			OP_ERR + 6'd0:  begin ma = mop_t'(an_q[1]); mb = v_q[2]; end
			OP_ERR + 6'd1:  begin ma = mop_t'(an_q[2]); mb = v_q[1]; end
			OP_ERR + 6'd2:  begin ma = mop_t'(an_q[2]); mb = v_q[0]; end
			OP_ERR + 6'd3:  begin ma = mop_t'(an_q[0]); mb = v_q[2]; end
			OP_ERR + 6'd4:  begin ma = mop_t'(an_q[0]); mb = v_q[1]; end
			OP_ERR + 6'd5:  begin ma = mop_t'(an_q[1]); mb = v_q[0]; end
			OP_PI + 6'd0:   begin ma = mop_t'(hp_q); mb = e_q[0]; end
			OP_PI + 6'd1:   begin ma = mop_t'(prop_q); mb = e_q[0]; end
			OP_PI + 6'd2:   begin ma = mop_t'(integ_q); mb = mop_t'(ei_q[0]); end
			OP_PI + 6'd3:   begin ma = mop_t'(hp_q); mb = e_q[1]; end
			OP_PI + 6'd4:   begin ma = mop_t'(prop_q); mb = e_q[1]; end
			OP_PI + 6'd5:   begin ma = mop_t'(integ_q); mb = mop_t'(ei_q[1]); end
			OP_PI + 6'd6:   begin ma = mop_t'(hp_q); mb = e_q[2]; end
			OP_PI + 6'd7:   begin ma = mop_t'(prop_q); mb = e_q[2]; end
			OP_PI + 6'd8:   begin ma = mop_t'(integ_q); mb = mop_t'(ei_q[2]); end
			OP_HALF + 6'd0: begin ma = mop_t'(hp_q); mb = mop_t'($signed(g_q[0][47:24])); end
			OP_HALF + 6'd1: begin ma = mop_t'(hp_q); mb = mop_t'(g_q[0][23:0]); end
			OP_HALF + 6'd2: begin ma = mop_t'(hp_q); mb = mop_t'($signed(g_q[1][47:24])); end
			OP_HALF + 6'd3: begin ma = mop_t'(hp_q); mb = mop_t'(g_q[1][23:0]); end
			OP_HALF + 6'd4: begin ma = mop_t'(hp_q); mb = mop_t'($signed(g_q[2][47:24])); end
			OP_HALF + 6'd5: begin ma = mop_t'(hp_q); mb = mop_t'(g_q[2][23:0]); end
			OP_STEP + 6'd0:  begin ma = mop_t'(q_q[1]); mb = mop_t'(h_q[0]); end
			OP_STEP + 6'd1:  begin ma = mop_t'(q_q[2]); mb = mop_t'(h_q[1]); end
			OP_STEP + 6'd2:  begin ma = mop_t'(q_q[3]); mb = mop_t'(h_q[2]); end
			OP_STEP + 6'd3:  begin ma = mop_t'(q_q[0]); mb = mop_t'(h_q[0]); end
			OP_STEP + 6'd4:  begin ma = mop_t'(q_q[2]); mb = mop_t'(h_q[2]); end
			OP_STEP + 6'd5:  begin ma = mop_t'(q_q[3]); mb = mop_t'(h_q[1]); end
			OP_STEP + 6'd6:  begin ma = mop_t'(q_q[0]); mb = mop_t'(h_q[1]); end
			OP_STEP + 6'd7:  begin ma = mop_t'(q_q[1]); mb = mop_t'(h_q[2]); end
			OP_STEP + 6'd8:  begin ma = mop_t'(q_q[3]); mb = mop_t'(h_q[0]); end
			OP_STEP + 6'd9:  begin ma = mop_t'(q_q[0]); mb = mop_t'(h_q[2]); end
			OP_STEP + 6'd10: begin ma = mop_t'(q_q[1]); mb = mop_t'(h_q[1]); end
			OP_STEP + 6'd11: begin ma = mop_t'(q_q[2]); mb = mop_t'(h_q[0]); end
			OP_NORM + 6'd0: begin ma = mop_t'(n_q[0]); mb = mop_t'(n_q[0]); end
			OP_NORM + 6'd1: begin ma = mop_t'(n_q[1]); mb = mop_t'(n_q[1]); end
			OP_NORM + 6'd2: begin ma = mop_t'(n_q[2]); mb = mop_t'(n_q[2]); end
			OP_NORM + 6'd3: begin ma = mop_t'(n_q[3]); mb = mop_t'(n_q[3]); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// dividend source: raw accel on the first pass, stepped quaternion on the second
	always_comb begin
		src_all[0] = pass_q ? n_q[0] : 34'(an_q[0]);
		src_all[1] = pass_q ? n_q[1] : 34'(an_q[1]);
		src_all[2] = pass_q ? n_q[2] : 34'(an_q[2]);
		src_all[3] = pass_q ? n_q[3] : '0;
	end

	assign div_sel  = (state_q == ST_SQRT) ? 2'd0 : div_idx_q + 2'd1;
	assign src_sel  = src_all[div_sel];
	assign src_mag  = src_sel[33] ? 34'(-src_sel) : 34'(src_sel);
	assign dvd_next = pass_q ? (DVD_W'(src_mag) << 28) : (DVD_W'(src_mag) << 45);

	// clamp the quotient to one and give it the dividend's sign
	assign mag31   = (quot > ONE30) ? 31'(ONE30) : quot[30:0];
	assign res_mag = {1'b0, mag31};
	assign div_res = src_all[div_idx_q][33] ? -res_mag : res_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			pass_q      <= 1'b0;
			op_q        <= '0;
			div_idx_q   <= '0;
			sq_start_q  <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			prop_q      <= PROP_GAIN_RST;
			integ_q     <= INTEGRAL_GAIN_RST;
			hp_q        <= HALF_PERIOD_RST;
			att_q[0]    <= QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);
			att_q[1]    <= '0;
			att_q[2]    <= '0;
			att_q[3]    <= '0;
			ei_q[0]     <= '0;
			ei_q[1]     <= '0;
			ei_q[2]     <= '0;
		end else begin
			// one-cycle start pulses for the root and divide units
			sq_start_q  <= (state_q == ST_MUL) && phase_q &&
				(((op_q == OP_ASQ + 6'd2) && (acc_plus != '0)) || (op_q == OP_LAST));
			div_start_q <= ((state_q == ST_SQRT) && sq_done && !(pass_q && sq_root == '0)) ||
				((state_q == ST_DIV) && div_done && !last_div);

			if (cfg_write) begin
				case (cfg_index)
					REG_PROP_GAIN:     prop_q  <= cfg_data[GAIN_W-1:0];
					REG_INTEGRAL_GAIN: integ_q <= cfg_data[GAIN_W-1:0];
					REG_HALF_PERIOD:   hp_q    <= cfg_data[HP_W-1:0];
					default: ;
				endcase
			end

			if (done_fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
						op_q    <= OP_ASQ;
						phase_q <= 1'b0;
					end
				end
				ST_MUL: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						case (op_q)
							OP_PI + 6'd0: ei_q[0] <= sat32(ACC_W'(ei_q[0]) + (pt >>> 26));
							OP_PI + 6'd3: ei_q[1] <= sat32(ACC_W'(ei_q[1]) + (pt >>> 26));
							OP_PI + 6'd6: ei_q[2] <= sat32(ACC_W'(ei_q[2]) + (pt >>> 26));
							default: ;
						endcase
						if (op_q == OP_ASQ + 6'd2) begin
							// no acceleration: skip the whole correction
							if (acc_plus == '0) begin
								op_q <= OP_HALF;
							end else begin
								state_q <= ST_SQRT;
								pass_q  <= 1'b0;
							end
						end else if (op_q == OP_LAST) begin
							state_q <= ST_SQRT;
							pass_q  <= 1'b1;
						end else begin
							op_q <= op_q + 6'd1;
						end
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						if (pass_q && sq_root == '0) begin
							// zero quaternion after the step: hold the attitude
							state_q <= ST_DONE;
						end else begin
							state_q   <= ST_DIV;
							div_idx_q <= '0;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (pass_q)
							att_q[div_idx_q] <= from30(div_res);
						if (last_div) begin
							if (pass_q) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_MUL;
								op_q    <= OP_GRAV;
								phase_q <= 1'b0;
							end
						end else begin
							div_idx_q <= div_idx_q + 2'd1;
						end
					end
				end
				ST_DONE: begin
					if (done_fire)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_q[0]  <= to30(att_q[0]);
			q_q[1]  <= to30(att_q[1]);
			q_q[2]  <= to30(att_q[2]);
			q_q[3]  <= to30(att_q[3]);
			an_q[0] <= 32'(accel_x);
			an_q[1] <= 32'(accel_y);
			an_q[2] <= 32'(accel_z);
			g_q[0]  <= 48'(rate_x) <<< 14;
			g_q[1]  <= 48'(rate_y) <<< 14;
			g_q[2]  <= 48'(rate_z) <<< 14;
		end

		if (state_q == ST_MUL && phase_q) begin
			case (op_q)
				OP_ASQ + 6'd0:  acc_q <= pt;
				OP_ASQ + 6'd1:  acc_q <= acc_plus;
				OP_ASQ + 6'd2:  sq_arg_q <= SQ_IN_W'(acc_plus[33:0]) << 30;
				OP_GRAV + 6'd0: acc_q <= m_p;
				OP_GRAV + 6'd1: v_q[0] <= MUL_W'(acc_mm <<< 1);
				OP_GRAV + 6'd2: acc_q <= m_p;
				OP_GRAV + 6'd3: v_q[1] <= MUL_W'(acc_pm <<< 1);
				OP_GRAV + 6'd4: acc_q <= m_p;
				OP_GRAV + 6'd5: acc_q <= acc_mm;
				OP_GRAV + 6'd6: acc_q <= acc_mm;
				OP_GRAV + 6'd7: v_q[2] <= MUL_W'(acc_pm);
				OP_ERR + 6'd0:  acc_q <= m_p;
				OP_ERR + 6'd1:  e_q[0] <= MUL_W'(acc_mm);
				OP_ERR + 6'd2:  acc_q <= m_p;
				OP_ERR + 6'd3:  e_q[1] <= MUL_W'(acc_mm);
				OP_ERR + 6'd4:  acc_q <= m_p;
				OP_ERR + 6'd5:  e_q[2] <= MUL_W'(acc_mm);
				OP_PI + 6'd1:   g_q[0] <= 48'(ACC_W'(g_q[0]) + (pt >>> 16));
				OP_PI + 6'd2:   g_q[0] <= 48'(ACC_W'(g_q[0]) + (pt >>> 14));
				OP_PI + 6'd4:   g_q[1] <= 48'(ACC_W'(g_q[1]) + (pt >>> 16));
				OP_PI + 6'd5:   g_q[1] <= 48'(ACC_W'(g_q[1]) + (pt >>> 14));
				OP_PI + 6'd7:   g_q[2] <= 48'(ACC_W'(g_q[2]) + (pt >>> 16));
				OP_PI + 6'd8:   g_q[2] <= 48'(ACC_W'(g_q[2]) + (pt >>> 14));
				OP_HALF + 6'd0: acc_q <= pt;
				OP_HALF + 6'd1: h_q[0] <= clamp29(acc_q + (pt >>> 24));
				OP_HALF + 6'd2: acc_q <= pt;
				OP_HALF + 6'd3: h_q[1] <= clamp29(acc_q + (pt >>> 24));
				OP_HALF + 6'd4: acc_q <= pt;
				OP_HALF + 6'd5: h_q[2] <= clamp29(acc_q + (pt >>> 24));
				OP_STEP + 6'd0:  acc_q <= -pt;
				OP_STEP + 6'd1:  acc_q <= acc_minus;
				OP_STEP + 6'd2:  n_q[0] <= 34'(ACC_W'(q_q[0]) + (acc_minus >>> 30));
				OP_STEP + 6'd3:  acc_q <= pt;
				OP_STEP + 6'd4:  acc_q <= acc_plus;
				OP_STEP + 6'd5:  n_q[1] <= 34'(ACC_W'(q_q[1]) + (acc_minus >>> 30));
				OP_STEP + 6'd6:  acc_q <= pt;
				OP_STEP + 6'd7:  acc_q <= acc_minus;
				OP_STEP + 6'd8:  n_q[2] <= 34'(ACC_W'(q_q[2]) + (acc_plus >>> 30));
				OP_STEP + 6'd9:  acc_q <= pt;
				OP_STEP + 6'd10: acc_q <= acc_plus;
				OP_STEP + 6'd11: n_q[3] <= 34'(ACC_W'(q_q[3]) + (acc_minus >>> 30));
				OP_NORM + 6'd0: acc_q <= pt >>> 4;
				OP_NORM + 6'd1: acc_q <= acc_sq;
				OP_NORM + 6'd2: acc_q <= acc_sq;
				OP_NORM + 6'd3: sq_arg_q <= SQ_IN_W'(acc_sq);
				default: ;
			endcase
		end

		if (state_q == ST_SQRT && sq_done) begin
			root_q <= sq_root;
			dvd_q  <= dvd_next;
		end

		if (state_q == ST_DIV && div_done) begin
			if (!pass_q)
				an_q[div_idx_q] <= div_res;
			dvd_q <= dvd_next;
		end

		if (done_fire) begin
			qw_q <= to30(att_q[0]);
			qx_q <= to30(att_q[1]);
			qy_q <= to30(att_q[2]);
			qz_q <= to30(att_q[3]);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign quat_w    = qw_q;
	assign quat_x    = qx_q;
	assign quat_y    = qy_q;
	assign quat_z    = qz_q;

endmodule

### sv/mau_mul.sv
// Shared signed multiplier with a registered product.
// Depends on mau_pkg for the operand type width.
module mau_mul #(
	parameter int W = mau_pkg::MUL_W
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	import mau_pkg::*;

	logic signed [2*W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

### sv/mau_isqrt.sv
// Iterative floor integer square root, one result bit per cycle.
// Depends on mau_pkg for default widths.
module mau_isqrt #(
	parameter int IN_W  = mau_pkg::SQ_IN_W,
	parameter int OUT_W = mau_pkg::ROOT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IN_W-1:0]  arg,
	output logic             done,
	output logic [OUT_W-1:0] root
);
	import mau_pkg::*;

	localparam int CNT_W = $clog2(OUT_W);

	logic [IN_W-1:0]  v_q, r_q, b_q;
	logic [IN_W-1:0]  rb;
	logic             take;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	assign rb   = r_q + b_q;
	assign take = (v_q >= rb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(OUT_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(OUT_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= arg;
			r_q <= '0;
			b_q <= IN_W'(1) << (IN_W - 2);
		end else if (busy_q) begin
			if (take) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[OUT_W-1:0];

endmodule

### sv/mau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mau_pkg for default widths.
module mau_div #(
	parameter int DVD_W = mau_pkg::DVD_W,
	parameter int DVS_W = mau_pkg::ROOT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	import mau_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DVS_W:0]   rem_sh, diff;
	logic             ge;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign ge     = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(DVD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### sim/mahony_attitude_checker.sv
// Checker for mahony_attitude_update: watches the config port and both channels,
// predicts each quaternion in fixed point and compares. Depends on mau_pkg.
module mahony_attitude_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [mau_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mau_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [mau_pkg::RATE_W-1:0]   rate_x,
	input  logic signed [mau_pkg::RATE_W-1:0]   rate_y,
	input  logic signed [mau_pkg::RATE_W-1:0]   rate_z,
	input  logic signed [mau_pkg::ACCEL_W-1:0]  accel_x,
	input  logic signed [mau_pkg::ACCEL_W-1:0]  accel_y,
	input  logic signed [mau_pkg::ACCEL_W-1:0]  accel_z,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [mau_pkg::QUAT_W-1:0]   quat_w,
	input  logic signed [mau_pkg::QUAT_W-1:0]   quat_x,
	input  logic signed [mau_pkg::QUAT_W-1:0]   quat_y,
	input  logic signed [mau_pkg::QUAT_W-1:0]   quat_z,
	output int                                  fail_count,
	output int                                  pending
);
	import mau_pkg::*;

	localparam longint ONE30 = 64'sd1 << 30;

	typedef struct {
		logic signed [QUAT_W-1:0] w, x, y, z;
	} quat_t;

	quat_t         quat_q[$];
	longint        att[4];
	longint        integ[3];
	longint        kp, ki, hp;

	function automatic longint clampv(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint mul30(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint half_step(longint g);
		longint gh, gl;
		gh = g >>> 24;
		gl = g - (gh <<< 24);
		return clampv(hp * gh + ((hp * gl) >>> 24), 64'sd1 << 29);
	endfunction

	// Advance the stored attitude by one sample and return the new quaternion.
	function automatic quat_t update_attitude(longint rx, longint ry, longint rz,
			longint ax, longint ay, longint az);
		longint q[4], a[3], e[3], g[3], h[3], n[4];
		longint vx, vy, vz, t;
		longint unsigned s, r;
		quat_t res;
		for (int i = 0; i < 4; i++) q[i] = att[i];
		a[0] = ax; a[1] = ay; a[2] = az;
		g[0] = rx * 16384; g[1] = ry * 16384; g[2] = rz * 16384;
		s = longint'(ax * ax + ay * ay + az * az);
		// zero acceleration: skip the correction, hold the integral
		if (s != 0) begin
			r = int_sqrt(s << 30);
			for (int i = 0; i < 3; i++)
				a[i] = clampv((a[i] * (64'sd1 <<< 45)) / longint'(r), ONE30);
			vx = 2 * (mul30(q[1], q[3]) - mul30(q[0], q[2]));
			vy = 2 * (mul30(q[0], q[1]) + mul30(q[2], q[3]));
			vz = mul30(q[0], q[0]) - mul30(q[1], q[1]) - mul30(q[2], q[2])
				+ mul30(q[3], q[3]);
			e[0] = mul30(a[1], vz) - mul30(a[2], vy);
			e[1] = mul30(a[2], vx) - mul30(a[0], vz);
			e[2] = mul30(a[0], vy) - mul30(a[1], vx);
			for (int i = 0; i < 3; i++) begin
				t = integ[i] + ((hp * e[i]) >>> 26);
				if (t > 64'sd2147483647) t = 64'sd2147483647;
				if (t < -64'sd2147483648) t = -64'sd2147483648;
				integ[i] = t;
				g[i] = g[i] + ((kp * e[i]) >>> 16) + ((ki * t) >>> 14);
			end
		end
		for (int i = 0; i < 3; i++) h[i] = half_step(g[i]);
		n[0] = q[0] + ((-q[1] * h[0] - q[2] * h[1] - q[3] * h[2]) >>> 30);
		n[1] = q[1] + ((q[0] * h[0] + q[2] * h[2] - q[3] * h[1]) >>> 30);
		n[2] = q[2] + ((q[0] * h[1] - q[1] * h[2] + q[3] * h[0]) >>> 30);
		n[3] = q[3] + ((q[0] * h[2] + q[1] * h[1] - q[2] * h[0]) >>> 30);
		s = 0;
		for (int i = 0; i < 4; i++) s = s + (longint'(n[i] * n[i]) >> 4);
		r = int_sqrt(s);
		// a zero quaternion after the step keeps the old attitude
		if (r != 0)
			for (int i = 0; i < 4; i++)
				att[i] = clampv((n[i] * (64'sd1 <<< 28)) / longint'(r), ONE30);
		res.w = att[0][31:0];
		res.x = att[1][31:0];
		res.y = att[2][31:0];
		res.z = att[3][31:0];
		return res;
	endfunction

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			if (fail_count < 10)
				$display("%s: expected %h, got %h", name, want, got);
			fail_count = fail_count + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		quat_t want;
		if (!arst_n) begin
			quat_q.delete();
			att[0] = ONE30;
			for (int i = 1; i < 4; i++) att[i] = 0;
			for (int i = 0; i < 3; i++) integ[i] = 0;
			kp = PROP_GAIN_RST;
			ki = INTEGRAL_GAIN_RST;
			hp = HALF_PERIOD_RST;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
				REG_PROP_GAIN:     kp = cfg_data[GAIN_W-1:0];
				REG_INTEGRAL_GAIN: ki = cfg_data[GAIN_W-1:0];
				REG_HALF_PERIOD:   hp = cfg_data[HP_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				quat_q.push_back(update_attitude(rate_x, rate_y, rate_z,
					accel_x, accel_y, accel_z));
			if (out_valid && !out_stall) begin
				if (quat_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h %h %h %h",
							quat_w, quat_x, quat_y, quat_z);
					fail_count = fail_count + 1;
				end else begin
					want = quat_q.pop_front();
					report_field("quat_w", want.w, quat_w);
					report_field("quat_x", want.x, quat_x);
					report_field("quat_y", want.y, quat_y);
					report_field("quat_z", want.z, quat_z);
				end
			end
			pending <= quat_q.size();
		end
	end
endmodule

### sim/testbench.sv
// Top of the attitude update testbench: clock, reset, stimulus, stalls and verdict.
// Depends on mau_pkg, mahony_attitude_update and mahony_attitude_checker.
module testbench;
	import mau_pkg::*;

	localparam int STALL_LIMIT = 40000;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       cfg_write = 0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       in_valid = 0;
	logic                       in_stall;
	logic signed [RATE_W-1:0]   rate_x = '0, rate_y = '0, rate_z = '0;
	logic signed [ACCEL_W-1:0]  accel_x = '0, accel_y = '0, accel_z = '0;
	logic                       out_valid;
	logic                       out_stall = 0;
	logic signed [QUAT_W-1:0]   quat_w, quat_x, quat_y, quat_z;
	int                         fail_count, pending;
	int                         idle_pct = 0, stall_pct = 0;
	int                         quiet_cycles = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	mahony_attitude_update DUT (.*);
	mahony_attitude_checker checker_i (.*);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("mahony_attitude_update: mismatch");
			$finish;
		end
	end

	task automatic send_sample(logic signed [31:0] rx, ry, rz, logic signed [15:0] ax, ay, az);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		rate_x <= rx; rate_y <= ry; rate_z <= rz;
		accel_x <= ax; accel_y <= ay; accel_z <= az;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 0;
	endtask

	task automatic set_gains(int pg, int ig, int hpv);
		write_reg(REG_PROP_GAIN, CFG_DATA_W'(pg));
		write_reg(REG_INTEGRAL_GAIN, CFG_DATA_W'(ig));
		write_reg(REG_HALF_PERIOD, CFG_DATA_W'(hpv));
	endtask

	function automatic logic signed [31:0] pick_rate();
		case ($urandom_range(9))
		0:       return $urandom;
		1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
		2, 3:    return $signed($urandom_range(2 << 20)) - (1 << 20);
		default: return $signed($urandom_range(1 << 18)) - (1 << 17);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_accel();
		case ($urandom_range(9))
		0:       return $urandom;
		1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		2:       return 0;
		default: return $signed($urandom_range(4000)) - 2000;
		endcase
	endfunction

	task automatic random_samples(int count);
		logic signed [15:0] ax, ay, az;
		for (int k = 0; k < count; k++) begin
			ax = pick_accel();
			ay = pick_accel();
			az = pick_accel();
			if ($urandom_range(19) == 0) begin
				ax = 0; ay = 0; az = 0;
			end else if ($urandom_range(3) != 0)
				az = az + 16'sd8192;
			send_sample(pick_rate(), pick_rate(), pick_rate(), ax, ay, az);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: rest, zero acceleration, field extremes, huge steps
		send_sample(0, 0, 0, 0, 0, 16'sd8192);
		send_sample(32'sh10000, 0, 0, 0, 0, 0);
		send_sample(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_sample(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(32'shffffffff, 32'sh1, 32'sh0, 16'sh1, 16'shffff, 16'sh0);
		send_sample(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 16'sh5555, 16'shaaaa, 16'sh0ff0);
		set_gains(18'h3ffff, 18'h3ffff, 24'hffffff);
		send_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh0, 16'sh0);
		send_sample(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh0, 16'sh8000, 16'sh0);
		send_sample(32'sh20000, 32'shfffe0000, 32'sh0, 16'sh0, 16'sh0, 16'sh7fff);
		for (int k = 0; k < 6; k++)
			send_sample(32'sh0, 32'sh0, 32'sh0, 16'sh7fff, 16'sh7fff, 16'sh8000);
		send_sample(32'sh7fffffff, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 16'sh0);
		set_gains(0, 0, 0);
		send_sample(32'sh7fffffff, 32'sh80000000, 32'sh1234, 16'sh100, 16'sh200, 16'sh300);
		write_reg(REG_UNUSED, 24'hffffff);
		send_sample(32'sh10000, 32'sh10000, 32'sh10000, 16'sh0, 16'sh0, 16'sh4000);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 85; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 85; end
			default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			case (phase)
			0: set_gains(PROP_GAIN_RST, INTEGRAL_GAIN_RST, HALF_PERIOD_RST);
			3: set_gains(18'h3ffff, 18'h3ffff, 24'hffffff);
			5: set_gains(0, 0, 1);
			7: set_gains(PROP_GAIN_RST, INTEGRAL_GAIN_RST, HALF_PERIOD_RST);
			default: set_gains($urandom_range(18'h3ffff), $urandom_range(18'h3ffff),
				$urandom_range(1, 24'hffffff));
			endcase
			random_samples(185);
		end

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("mahony_attitude_update: match");
		else
			$display("mahony_attitude_update: mismatch");
		$finish;
	end
endmodule
